FILE: sv/acb_pkg.sv
package acb_pkg;

    // Pixel grid side; pixels at or beyond it are never painted
    localparam int SIDE_PIXELS = 256;

    // Projection divider: 8 quotient bits, two per stage
    localparam int T_DIV_STAGES = 4;
    localparam int T_DIV_STEPS  = 2;

    // Distance square root: 21 root bits, three per stage
    localparam int DIST_W       = 21;
    localparam int SQRT_STAGES  = 7;
    localparam int SQRT_STEPS   = 3;

    // Blend divider: 8 quotient bits, two per stage
    localparam int MIX_DIV_STAGES = 4;
    localparam int MIX_DIV_STEPS  = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_X     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_Y     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_X       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_Y       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAINT_COLOR = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAINT_ALPHA = 3'd6;

    typedef struct packed {
        logic signed [13:0] start_x;
        logic signed [13:0] start_y;
        logic signed [13:0] end_x;
        logic signed [13:0] end_y;
        logic [11:0]        radius;
        logic [23:0]        color;
        logic [7:0]         alpha;
    } cfg_t;

    // Destination pixel and canvas flag, carried alongside the math
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       on_canvas;
    } pix_side_t;

endpackage

FILE: sv/acb_geom.sv
module acb_geom (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  acb_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    input  logic [7:0]           in_x,
    input  logic [7:0]           in_y,
    input  acb_pkg::pix_side_t   in_side,
    output logic                 out_valid,
    output logic signed [16:0]   out_qx,
    output logic signed [16:0]   out_qy,
    output acb_pkg::pix_side_t   out_side
);

    localparam int NS    = acb_pkg::T_DIV_STAGES;
    localparam int STEPS = acb_pkg::T_DIV_STEPS;

    typedef struct packed {
        logic [29:0] rem;
        logic [7:0]  q;
    } tdiv_t;

    function automatic tdiv_t t_step(input tdiv_t cur, input logic [29:0] den);
        logic [30:0] r2;
        tdiv_t       res;
        r2 = {cur.rem, 1'b0};
        if (r2 >= {1'b0, den})
        begin
            res.rem = 30'(r2 - {1'b0, den});
            res.q   = {cur.q[6:0], 1'b1};
        end
        else
        begin
            res.rem = r2[29:0];
            res.q   = {cur.q[6:0], 1'b0};
        end
        return res;
    endfunction

    // Segment vector from the live registers
    logic signed [14:0] vx, vy;
    assign vx = 15'(cfg.end_x) - 15'(cfg.start_x);
    assign vy = 15'(cfg.end_y) - 15'(cfg.start_y);

    // Input stage
    logic               v0_reg;
    logic [7:0]         x0_reg, y0_reg;
    acb_pkg::pix_side_t side0_reg;

    logic signed [14:0] px, py;
    assign px = $signed({3'b000, x0_reg, 4'b0000}) - 15'(cfg.start_x);
    assign py = $signed({3'b000, y0_reg, 4'b0000}) - 15'(cfg.start_y);

    logic signed [29:0] mx, my, sx2, sy2;
    assign mx  = 30'(px) * 30'(vx);
    assign my  = 30'(py) * 30'(vy);
    assign sx2 = 30'(vx) * 30'(vx);
    assign sy2 = 30'(vy) * 30'(vy);

    logic signed [30:0] dot_next;
    logic [29:0]        len_next;
    assign dot_next = 31'(mx) + 31'(my);
    assign len_next = $unsigned(sx2 + sy2);

    // Dot product stage
    logic               v1_reg;
    logic signed [30:0] dot1_reg;
    logic [29:0]        len1_reg;
    logic signed [14:0] px1_reg, py1_reg;
    acb_pkg::pix_side_t side1_reg;

    logic  zero_next, full_next;
    tdiv_t setup;
    assign zero_next = (len1_reg == 30'd0) || (dot1_reg <= 31'sd0);
    assign full_next = !zero_next && (dot1_reg[29:0] >= len1_reg);
    assign setup.rem = (zero_next || full_next) ? 30'd0 : dot1_reg[29:0];
    assign setup.q   = 8'd0;

    // Divider stages
    logic               dv_reg   [NS];
    tdiv_t              dd_reg   [NS];
    tdiv_t              dd_next  [NS];
    logic [29:0]        den_reg  [NS];
    logic               zero_reg [NS];
    logic               full_reg [NS];
    logic signed [14:0] dpx_reg  [NS];
    logic signed [14:0] dpy_reg  [NS];
    acb_pkg::pix_side_t dside_reg[NS];

    always_comb
    begin
        tdiv_t       cur;
        logic [29:0] den;
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                cur = setup;
                den = len1_reg;
            end
            else
            begin
                cur = dd_reg[(k == 0) ? 0 : k - 1];
                den = den_reg[(k == 0) ? 0 : k - 1];
            end
            for (int s = 0; s < STEPS; s++)
            begin
                cur = t_step(cur, den);
            end
            dd_next[k] = cur;
        end
    end

    // Closest point offset
    logic [8:0]         t_val;
    logic signed [23:0] mulx, muly;
    logic signed [15:0] offx, offy;
    logic signed [16:0] qx_next, qy_next;

    assign t_val = full_reg[NS-1] ? 9'd256 :
                   zero_reg[NS-1] ? 9'd0   : {1'b0, dd_reg[NS-1].q};
    assign mulx  = 24'(vx) * 24'($signed({1'b0, t_val}));
    assign muly  = 24'(vy) * 24'($signed({1'b0, t_val}));
    // Truncate toward zero on the divide by 256
    assign offx  = mulx[23] ? 16'((mulx + 24'sd255) >>> 8) : 16'(mulx >>> 8);
    assign offy  = muly[23] ? 16'((muly + 24'sd255) >>> 8) : 16'(muly >>> 8);
    assign qx_next = 17'(dpx_reg[NS-1]) - 17'(offx);
    assign qy_next = 17'(dpy_reg[NS-1]) - 17'(offy);

    logic               vq_reg;
    logic signed [16:0] qx_reg, qy_reg;
    acb_pkg::pix_side_t sideq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vq_reg <= 1'b0;
            for (int k = 0; k < NS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            dv_reg[0] <= v1_reg;
            for (int k = 1; k < NS; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            vq_reg <= dv_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg       <= in_x;
            y0_reg       <= in_y;
            side0_reg    <= in_side;
            dot1_reg     <= dot_next;
            len1_reg     <= len_next;
            px1_reg      <= px;
            py1_reg      <= py;
            side1_reg    <= side0_reg;
            dd_reg[0]    <= dd_next[0];
            den_reg[0]   <= len1_reg;
            zero_reg[0]  <= zero_next;
            full_reg[0]  <= full_next;
            dpx_reg[0]   <= px1_reg;
            dpy_reg[0]   <= py1_reg;
            dside_reg[0] <= side1_reg;
            for (int k = 1; k < NS; k++)
            begin
                dd_reg[k]    <= dd_next[k];
                den_reg[k]   <= den_reg[k-1];
                zero_reg[k]  <= zero_reg[k-1];
                full_reg[k]  <= full_reg[k-1];
                dpx_reg[k]   <= dpx_reg[k-1];
                dpy_reg[k]   <= dpy_reg[k-1];
                dside_reg[k] <= dside_reg[k-1];
            end
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            sideq_reg <= dside_reg[NS-1];
        end
    end

    assign out_valid = vq_reg;
    assign out_qx    = qx_reg;
    assign out_qy    = qy_reg;
    assign out_side  = sideq_reg;

endmodule

FILE: sv/acb_sqrt.sv
module acb_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic signed [16:0]          in_qx,
    input  logic signed [16:0]          in_qy,
    input  acb_pkg::pix_side_t          in_side,
    output logic                        out_valid,
    output logic [acb_pkg::DIST_W-1:0]  out_dist,
    output acb_pkg::pix_side_t          out_side
);

    localparam int NS    = acb_pkg::SQRT_STAGES;
    localparam int STEPS = acb_pkg::SQRT_STEPS;
    localparam int RW    = acb_pkg::DIST_W;
    localparam int RAD_W = 2 * RW;
    localparam int REM_W = RW + 2;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [RW-1:0]    root;
    } sq_state_t;

    function automatic sq_state_t sq_step(input sq_state_t cur);
        logic [REM_W+1:0] rem2;
        logic [REM_W+1:0] trial;
        sq_state_t        res;
        rem2  = {cur.rem, cur.rad[RAD_W-1 -: 2]};
        trial = {2'b00, cur.root, 2'b01};
        if (rem2 >= trial)
        begin
            res.rem  = REM_W'(rem2 - trial);
            res.root = {cur.root[RW-2:0], 1'b1};
        end
        else
        begin
            res.rem  = rem2[REM_W-1:0];
            res.root = {cur.root[RW-2:0], 1'b0};
        end
        res.rad = {cur.rad[RAD_W-3:0], 2'b00};
        return res;
    endfunction

    logic signed [33:0] sqx, sqy, sq_sum;
    assign sqx    = 34'(in_qx) * 34'(in_qx);
    assign sqy    = 34'(in_qy) * 34'(in_qy);
    assign sq_sum = sqx + sqy;

    logic               vs_reg;
    logic [32:0]        sq_reg;
    acb_pkg::pix_side_t sides_reg;

    sq_state_t setup;
    assign setup.rad  = RAD_W'({sq_reg, 8'h00});
    assign setup.rem  = '0;
    assign setup.root = '0;

    logic               rv_reg   [NS];
    sq_state_t          rs_reg   [NS];
    sq_state_t          rs_next  [NS];
    acb_pkg::pix_side_t rside_reg[NS];

    always_comb
    begin
        sq_state_t cur;
        for (int k = 0; k < NS; k++)
        begin
            cur = (k == 0) ? setup : rs_reg[(k == 0) ? 0 : k - 1];
            for (int s = 0; s < STEPS; s++)
            begin
                cur = sq_step(cur);
            end
            rs_next[k] = cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= 1'b0;
            for (int k = 0; k < NS; k++)
            begin
                rv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vs_reg    <= in_valid;
            rv_reg[0] <= vs_reg;
            for (int k = 1; k < NS; k++)
            begin
                rv_reg[k] <= rv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg       <= sq_sum[32:0];
            sides_reg    <= in_side;
            rs_reg[0]    <= rs_next[0];
            rside_reg[0] <= sides_reg;
            for (int k = 1; k < NS; k++)
            begin
                rs_reg[k]    <= rs_next[k];
                rside_reg[k] <= rside_reg[k-1];
            end
        end
    end

    assign out_valid = rv_reg[NS-1];
    assign out_dist  = rs_reg[NS-1].root;
    assign out_side  = rside_reg[NS-1];

endmodule

FILE: sv/acb_blend.sv
module acb_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  acb_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  logic [acb_pkg::DIST_W-1:0]  in_dist,
    input  acb_pkg::pix_side_t          in_side,
    output logic                        out_valid,
    output logic [7:0]                  out_red,
    output logic [7:0]                  out_green,
    output logic [7:0]                  out_blue,
    output logic [7:0]                  out_alpha,
    output logic                        out_written
);

    localparam int NS    = acb_pkg::MIX_DIV_STAGES;
    localparam int STEPS = acb_pkg::MIX_DIV_STEPS;

    // floor(x / 255): reciprocal estimate, then two corrections
    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [32:0] prod;
        logic [16:0] q;
        logic [25:0] r;
        prod = 33'(x) * 33'd257;
        q    = prod[32:16];
        r    = 26'(x) - 26'(q) * 26'd255;
        if (r >= 26'd255)
        begin
            q = q + 17'd1;
            r = r - 26'd255;
        end
        if (r >= 26'd255)
        begin
            q = q + 17'd1;
        end
        return q[15:0];
    endfunction

    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] q;
    } mdiv_t;

    function automatic mdiv_t m_step(input mdiv_t cur, input logic [7:0] den);
        logic [8:0] r2;
        mdiv_t      res;
        r2 = {cur.rem, cur.low[7]};
        if (r2 >= {1'b0, den})
        begin
            res.rem = 8'(r2 - {1'b0, den});
            res.q   = {cur.q[6:0], 1'b1};
        end
        else
        begin
            res.rem = r2[7:0];
            res.q   = {cur.q[6:0], 1'b0};
        end
        res.low = {cur.low[6:0], 1'b0};
        return res;
    endfunction

    // Edge coverage
    logic [15:0]        r16;
    logic signed [22:0] edge_dist;
    logic [11:0]        ramp;
    logic [7:0]         cov;
    logic [15:0]        araw_next;

    assign r16       = {cfg.radius, 4'b0000};
    assign edge_dist = $signed({7'b0, r16}) - $signed({2'b0, in_dist});
    assign ramp      = 12'(edge_dist[3:0]) * 12'd255;

    always_comb
    begin
        if (edge_dist <= 23'sd0)
        begin
            cov = 8'd0;
        end
        else if (edge_dist >= 23'sd16)
        begin
            cov = 8'd255;
        end
        else
        begin
            cov = ramp[11:4];
        end
    end

    assign araw_next = 16'(cov) * 16'(cfg.alpha);

    logic [7:0] src_c[3];
    assign src_c[0] = cfg.color[23:16];
    assign src_c[1] = cfg.color[15:8];
    assign src_c[2] = cfg.color[7:0];

    // Stage 0: raw coverage times opacity
    logic               v0_reg;
    logic [15:0]        araw0_reg;
    acb_pkg::pix_side_t side0_reg;

    // Stage 1: effective alpha
    logic               v1_reg;
    logic [7:0]         a1_reg;
    acb_pkg::pix_side_t side1_reg;
    logic [15:0]        a1_full;
    assign a1_full = div255(24'(araw0_reg));

    // Stage 2: products against alpha
    logic               v2_reg;
    logic [7:0]         a2_reg;
    logic [15:0]        pda2_reg;
    logic [15:0]        sa2_reg[3];
    acb_pkg::pix_side_t side2_reg;

    logic [7:0] dst1_c[3];
    assign dst1_c[0] = side1_reg.red;
    assign dst1_c[1] = side1_reg.green;
    assign dst1_c[2] = side1_reg.blue;

    // Stage 3: output alpha and weighted destination
    logic               v3_reg;
    logic [7:0]         a3_reg;
    logic [7:0]         na3_reg;
    logic [15:0]        sa3_reg[3];
    logic [23:0]        pp3_reg[3];
    acb_pkg::pix_side_t side3_reg;

    logic [7:0] dst2_c[3];
    assign dst2_c[0] = side2_reg.red;
    assign dst2_c[1] = side2_reg.green;
    assign dst2_c[2] = side2_reg.blue;

    logic [8:0] na_next;
    assign na_next = 9'(a2_reg) + 9'(div255(24'(pda2_reg)));

    // Stage 4: blend numerators
    logic               v4_reg;
    logic [7:0]         a4_reg;
    logic [7:0]         na4_reg;
    logic [16:0]        num4_reg[3];
    acb_pkg::pix_side_t side4_reg;

    logic  sat_next[3];
    mdiv_t setup[3];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sat_next[c]  = num4_reg[c] >= 17'({na4_reg, 8'h00});
            setup[c].rem = num4_reg[c][15:8];
            setup[c].low = num4_reg[c][7:0];
            setup[c].q   = 8'd0;
        end
    end

    // Divider stages
    logic               dv_reg   [NS];
    mdiv_t              dd_reg   [NS][3];
    mdiv_t              dd_next  [NS][3];
    logic               sat_reg  [NS][3];
    logic [7:0]         a_reg    [NS];
    logic [7:0]         na_reg   [NS];
    acb_pkg::pix_side_t dside_reg[NS];

    always_comb
    begin
        mdiv_t      cur;
        logic [7:0] den;
        for (int k = 0; k < NS; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cur = (k == 0) ? setup[c] : dd_reg[(k == 0) ? 0 : k - 1][c];
                den = (k == 0) ? na4_reg : na_reg[(k == 0) ? 0 : k - 1];
                for (int s = 0; s < STEPS; s++)
                begin
                    cur = m_step(cur, den);
                end
                dd_next[k][c] = cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k < NS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int k = 1; k < NS; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            araw0_reg <= araw_next;
            side0_reg <= in_side;

            a1_reg    <= a1_full[7:0];
            side1_reg <= side0_reg;

            a2_reg    <= a1_reg;
            pda2_reg  <= 16'(side1_reg.alpha) * 16'(8'd255 - a1_reg);
            side2_reg <= side1_reg;

            a3_reg    <= a2_reg;
            na3_reg   <= na_next[7:0];
            side3_reg <= side2_reg;

            a4_reg    <= a3_reg;
            na4_reg   <= na3_reg;
            side4_reg <= side3_reg;

            for (int c = 0; c < 3; c++)
            begin
                sa2_reg[c]  <= 16'(src_c[c]) * 16'(a1_reg);
                sa3_reg[c]  <= sa2_reg[c];
                pp3_reg[c]  <= 24'(dst2_c[c]) * 24'(pda2_reg);
                num4_reg[c] <= 17'(sa3_reg[c]) + 17'(div255(pp3_reg[c]));
                dd_reg[0][c]  <= dd_next[0][c];
                sat_reg[0][c] <= sat_next[c];
            end
            a_reg[0]     <= a4_reg;
            na_reg[0]    <= na4_reg;
            dside_reg[0] <= side4_reg;

            for (int k = 1; k < NS; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    dd_reg[k][c]  <= dd_next[k][c];
                    sat_reg[k][c] <= sat_reg[k-1][c];
                end
                a_reg[k]     <= a_reg[k-1];
                na_reg[k]    <= na_reg[k-1];
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    // Result: blended pixel, or the destination passed through untouched
    logic       hit;
    logic [7:0] mix_c[3];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mix_c[c] = sat_reg[NS-1][c] ? 8'd255 : dd_reg[NS-1][c].q;
        end
    end

    assign hit         = (a_reg[NS-1] != 8'd0) && dside_reg[NS-1].on_canvas;
    assign out_valid   = dv_reg[NS-1];
    assign out_red     = hit ? mix_c[0] : dside_reg[NS-1].red;
    assign out_green   = hit ? mix_c[1] : dside_reg[NS-1].green;
    assign out_blue    = hit ? mix_c[2] : dside_reg[NS-1].blue;
    assign out_alpha   = hit ? na_reg[NS-1] : dside_reg[NS-1].alpha;
    assign out_written = hit;

endmodule

FILE: sv/antialiased_capsule_blend_core.sv
// Anti-aliased capsule coverage with source-over blend, one pixel per transfer.
// Throughput: one pixel per cycle; every stage is pipelined (7 geometry/divider,
// 8 square root, 9 blend/divider stages, 1 output register) and all stages
// advance together whenever the output register is free or being taken.
// Reset: rst_n clears all valid bits and loads the register defaults.
module antialiased_capsule_blend_core #(
    parameter int SIDE_PIXELS = acb_pkg::SIDE_PIXELS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         pix_x,
    input  logic [7:0]                         pix_y,
    input  logic [7:0]                         dest_red,
    input  logic [7:0]                         dest_green,
    input  logic [7:0]                         dest_blue,
    input  logic [7:0]                         dest_alpha,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         out_red,
    output logic [7:0]                         out_green,
    output logic [7:0]                         out_blue,
    output logic [7:0]                         out_alpha,
    output logic                               written,

    input  logic                               cfg_write,
    input  logic [acb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    acb_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x <= '0;
            cfg_reg.start_y <= '0;
            cfg_reg.end_x   <= '0;
            cfg_reg.end_y   <= '0;
            cfg_reg.radius  <= '0;
            cfg_reg.color   <= '0;
            cfg_reg.alpha   <= 8'd255;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                acb_pkg::CFG_START_X:     cfg_reg.start_x <= $signed(cfg_data[13:0]);
                acb_pkg::CFG_START_Y:     cfg_reg.start_y <= $signed(cfg_data[13:0]);
                acb_pkg::CFG_END_X:       cfg_reg.end_x   <= $signed(cfg_data[13:0]);
                acb_pkg::CFG_END_Y:       cfg_reg.end_y   <= $signed(cfg_data[13:0]);
                acb_pkg::CFG_RADIUS:      cfg_reg.radius  <= cfg_data[11:0];
                acb_pkg::CFG_PAINT_COLOR: cfg_reg.color   <= cfg_data[23:0];
                acb_pkg::CFG_PAINT_ALPHA: cfg_reg.alpha   <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // Whole pipeline advances as one; hold everything while a finished
    // result sits in the output register and the consumer stalls.
    logic out_valid_reg;
    logic adv;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Destination values and canvas test travel with each pixel
    acb_pkg::pix_side_t in_side;
    assign in_side.red       = dest_red;
    assign in_side.green     = dest_green;
    assign in_side.blue      = dest_blue;
    assign in_side.alpha     = dest_alpha;
    assign in_side.on_canvas = (11'(pix_x) < 11'(SIDE_PIXELS)) &&
                               (11'(pix_y) < 11'(SIDE_PIXELS));

    // Projection onto the segment and closest-point offset
    logic                geo_valid;
    logic signed [16:0]  geo_qx, geo_qy;
    acb_pkg::pix_side_t  geo_side;

    acb_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_x      (pix_x),
        .in_y      (pix_y),
        .in_side   (in_side),
        .out_valid (geo_valid),
        .out_qx    (geo_qx),
        .out_qy    (geo_qy),
        .out_side  (geo_side)
    );

    // Distance in 256ths of a pixel
    logic                             dist_valid;
    logic [acb_pkg::DIST_W-1:0]       dist_val;
    acb_pkg::pix_side_t               dist_side;

    acb_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (geo_valid),
        .in_qx     (geo_qx),
        .in_qy     (geo_qy),
        .in_side   (geo_side),
        .out_valid (dist_valid),
        .out_dist  (dist_val),
        .out_side  (dist_side)
    );

    // Coverage and source-over blend
    logic       blend_valid;
    logic [7:0] blend_red, blend_green, blend_blue, blend_alpha;
    logic       blend_written;

    acb_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .cfg         (cfg_reg),
        .in_valid    (dist_valid),
        .in_dist     (dist_val),
        .in_side     (dist_side),
        .out_valid   (blend_valid),
        .out_red     (blend_red),
        .out_green   (blend_green),
        .out_blue    (blend_blue),
        .out_alpha   (blend_alpha),
        .out_written (blend_written)
    );

    // Output register: hold the result until the transfer completes
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic       written_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= blend_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg     <= blend_red;
            green_reg   <= blend_green;
            blue_reg    <= blend_blue;
            alpha_reg   <= blend_alpha;
            written_reg <= blend_written;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;
    assign written   = written_reg;

endmodule

FILE: test/antialiased_capsule_blend_core_test.sv
`timescale 1ns / 1ps

module antialiased_capsule_blend_core_test;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       written;
    } blend_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      pix_x;
    logic [7:0]                      pix_y;
    logic [7:0]                      dest_red;
    logic [7:0]                      dest_green;
    logic [7:0]                      dest_blue;
    logic [7:0]                      dest_alpha;
    logic                            out_valid;
    logic                            out_stall;
    logic [7:0]                      out_red;
    logic [7:0]                      out_green;
    logic [7:0]                      out_blue;
    logic [7:0]                      out_alpha;
    logic                            written;
    logic                            cfg_write;
    logic [acb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [acb_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the shape and paint registers
    longint                 seg_sx;
    longint                 seg_sy;
    longint                 seg_ex;
    longint                 seg_ey;
    longint                 seg_radius;
    int unsigned            paint_rgb;
    int unsigned            paint_opacity;

    blend_result_t          pending_pixels[$];
    int                     error_count;
    bit                     steady;        // no idling on either side
    int                     hold_left;     // receiver hold-off cycles remaining

    antialiased_capsule_blend_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .dest_red   (dest_red),
        .dest_green (dest_green),
        .dest_blue  (dest_blue),
        .dest_alpha (dest_alpha),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .written    (written),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    // Floor square root, one root bit per pass from the top down
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 23; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Straight-alpha blend of one channel, saturated to 8 bits
    function automatic logic [7:0] blend_channel(int unsigned src, int unsigned dst,
                                                 int unsigned a, int unsigned da,
                                                 int unsigned na);
        int unsigned q;
        q = (src * a + dst * da * (255 - a) / 255) / na;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Coverage of the capsule at one pixel, then the blend into it
    function automatic blend_result_t paint_pixel(logic [7:0] x, logic [7:0] y,
                                                  logic [7:0] dr, logic [7:0] dg,
                                                  logic [7:0] db, logic [7:0] da);
        blend_result_t   res;
        longint          vx;
        longint          vy;
        longint          len2;
        longint          px;
        longint          py;
        longint          t;
        longint          qx;
        longint          qy;
        longint          span;
        longint          edge_gap;
        int unsigned     cov;
        int unsigned     a;
        int unsigned     na;
        vx = seg_ex - seg_sx;
        vy = seg_ey - seg_sy;
        len2 = vx * vx + vy * vy;
        px = longint'(x) * 16 - seg_sx;
        py = longint'(y) * 16 - seg_sy;
        t = 0;
        if (len2 > 0)
        begin
            t = (px * vx + py * vy) * 256 / len2;
            if (t < 0)
                t = 0;
            if (t > 256)
                t = 256;
        end
        qx = px - vx * t / 256;
        qy = py - vy * t / 256;
        span = longint'(floor_root(longint'(qx * qx + qy * qy) * 256));
        edge_gap = seg_radius * 16 - span;
        if (edge_gap <= 0)
            cov = 0;
        else if (edge_gap >= 16)
            cov = 255;
        else
            cov = int'(edge_gap * 255 / 16);
        a = cov * paint_opacity / 255;
        res = '{red: dr, green: dg, blue: db, alpha: da, written: 1'b0};
        if (a > 0 && int'(x) < acb_pkg::SIDE_PIXELS && int'(y) < acb_pkg::SIDE_PIXELS)
        begin
            na = a + da * (255 - a) / 255;
            res.red = blend_channel((paint_rgb >> 16) & 8'hFF, dr, a, da, na);
            res.green = blend_channel((paint_rgb >> 8) & 8'hFF, dg, a, da, na);
            res.blue = blend_channel(paint_rgb & 8'hFF, db, a, da, na);
            res.alpha = na[7:0];
            res.written = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    // Offer one pixel; return at the edge where the transfer happens
    task automatic send_pixel(logic [7:0] x, logic [7:0] y, logic [7:0] dr,
                              logic [7:0] dg, logic [7:0] db, logic [7:0] da);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 28)
            gap = $urandom_range(1, 2);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pix_x <= x;
        pix_y <= y;
        dest_red <= dr;
        dest_green <= dg;
        dest_blue <= db;
        dest_alpha <= da;
        do
            @(posedge clk);
        while (in_stall);
        pending_pixels.push_back(paint_pixel(x, y, dr, dg, db, da));
    endtask

    task automatic send_random_pixel();
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
    endtask

    // Drop valid and wait until the pipeline has emptied
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(logic [acb_pkg::CFG_INDEX_W-1:0] idx, int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[acb_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            acb_pkg::CFG_START_X:     seg_sx = longint'($signed(value[13:0]));
            acb_pkg::CFG_START_Y:     seg_sy = longint'($signed(value[13:0]));
            acb_pkg::CFG_END_X:       seg_ex = longint'($signed(value[13:0]));
            acb_pkg::CFG_END_Y:       seg_ey = longint'($signed(value[13:0]));
            acb_pkg::CFG_RADIUS:      seg_radius = longint'(value & 12'hFFF);
            acb_pkg::CFG_PAINT_COLOR: paint_rgb = value & 24'hFFFFFF;
            acb_pkg::CFG_PAINT_ALPHA: paint_opacity = value & 8'hFF;
            default: ;
        endcase
    endtask

    task automatic set_shape(int sx, int sy, int ex, int ey, int r, int rgb, int op);
        drain_pipeline();
        write_reg(acb_pkg::CFG_START_X, sx);
        write_reg(acb_pkg::CFG_START_Y, sy);
        write_reg(acb_pkg::CFG_END_X, ex);
        write_reg(acb_pkg::CFG_END_Y, ey);
        write_reg(acb_pkg::CFG_RADIUS, r);
        write_reg(acb_pkg::CFG_PAINT_COLOR, rgb);
        write_reg(acb_pkg::CFG_PAINT_ALPHA, op);
    endtask

    // Reset values: zero radius, so nothing is painted
    task automatic test_reset_defaults();
        send_pixel(8'd0, 8'd0, 8'd12, 8'd34, 8'd56, 8'd78);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // Zero-length segment: a disc, full, partial and zero opacity
    task automatic test_disc();
        set_shape(0, 0, 0, 0, 4095, 24'hFFFFFF, 255);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd3, 8'd10, 8'd200, 8'd90, 8'd0);
        set_shape(2048, 2048, 2048, 2048, 40, 24'h80FF01, 1);
        send_pixel(8'd128, 8'd128, 8'd255, 8'd0, 8'd255, 8'd255);
        send_pixel(8'd130, 8'd128, 8'd1, 8'd2, 8'd3, 8'd4);
        // walk across the soft edge
        for (int i = 125; i <= 131; i++)
            send_pixel(8'(i), 8'd128, 8'd200, 8'd100, 8'd50, 8'd128);
        set_shape(2048, 2048, 2048, 2048, 4095, 24'h123456, 0);
        send_pixel(8'd128, 8'd128, 8'd9, 8'd8, 8'd7, 8'd6);
    endtask

    // Segment spanning the full register range, both directions
    task automatic test_long_segment();
        set_shape(-8192, -8192, 8191, 8191, 0, 24'h00FF00, 255);
        send_pixel(8'd100, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0);
        set_shape(8191, -8192, -8192, 8191, 23, 24'hFF0000, 200);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd100);
        send_pixel(8'd255, 8'd0, 8'd30, 8'd40, 8'd50, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd30, 8'd40, 8'd50, 8'd1);
    endtask

    // Random shapes with pixels clustered around the capsule
    task automatic test_random_shapes(int phases, int per_phase);
        int sx, sy, ex, ey, r, t, ox, oy, cx, cy;
        for (int ph = 0; ph < phases; ph++)
        begin
            steady = (ph == 2);
            sx = $urandom_range(4095) - 256;
            sy = $urandom_range(4095) - 256;
            ex = ($urandom_range(3) == 0) ? sx : $urandom_range(4095) - 256;
            ey = ($urandom_range(3) == 0) ? sy : $urandom_range(4095) - 256;
            r = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(400);
            set_shape(sx, sy, ex, ey, r, $urandom, $urandom_range(255));
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(9) < 7)
                begin
                    t = $urandom_range(256);
                    ox = $urandom_range(2 * r + 64) - r - 32;
                    oy = $urandom_range(2 * r + 64) - r - 32;
                    cx = (sx + (ex - sx) * t / 256 + ox) / 16;
                    cy = (sy + (ey - sy) * t / 256 + oy) / 16;
                    cx = (cx < 0) ? 0 : (cx > 255) ? 255 : cx;
                    cy = (cy < 0) ? 0 : (cy > 255) ? 255 : cy;
                    send_pixel(8'(cx), 8'(cy), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom));
                end
                else
                    send_random_pixel();
            end
        end
        steady = 1'b0;
    endtask

    // Hold the output long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        set_shape(2048, 2048, 1000, 3000, 600, 24'hA0B0C0, 180);
        steady = 1'b1;
        hold_left <= 200;
        for (int i = 0; i < 80; i++)
            send_random_pixel();
        steady = 1'b0;
    endtask

    // Receiver: random stall, quiet during steady stretches, forced on hold
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= !steady && ($urandom_range(99) < 28);
    end

    // Compare every output transfer with the oldest expected pixel
    always @(posedge clk)
    begin
        blend_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("output transfer with no pixel pending at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_red !== want.red)
                    report_mismatch("out_red", out_red, want.red);
                if (out_green !== want.green)
                    report_mismatch("out_green", out_green, want.green);
                if (out_blue !== want.blue)
                    report_mismatch("out_blue", out_blue, want.blue);
                if (out_alpha !== want.alpha)
                    report_mismatch("out_alpha", out_alpha, want.alpha);
                if (written !== want.written)
                    report_mismatch("written", written, want.written);
            end
        end
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pix_x = '0;
        pix_y = '0;
        dest_red = '0;
        dest_green = '0;
        dest_blue = '0;
        dest_alpha = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        steady = 1'b0;
        hold_left = 0;
        seg_sx = 0;
        seg_sy = 0;
        seg_ex = 0;
        seg_ey = 0;
        seg_radius = 0;
        paint_rgb = 0;
        paint_opacity = 255;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_disc();
        test_long_segment();
        test_backpressure();
        test_random_shapes(6, 225);
        drain_pipeline();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
